// ===== design/outlier_trimmed_window_mean_macros.svh =====
// assertion macros for the trimmed window mean checker
`ifndef OUTLIER_TRIMMED_WINDOW_MEAN_MACROS_SVH
`define OUTLIER_TRIMMED_WINDOW_MEAN_MACROS_SVH

`define OTWM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define OTWM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/otwm_pkg.sv =====
`default_nettype none
package otwm_pkg;
   localparam int unsigned Window = 16;
   localparam int unsigned SlotW = $clog2(Window);
   localparam int unsigned CntW = $clog2(Window + 1);
   localparam int unsigned SumW = 16 + CntW;
   localparam int unsigned NumAxes = 3;

   typedef logic signed [15:0] sample_type;
   typedef logic [SlotW-1:0] slot_type;
   typedef logic [CntW-1:0] cnt_type;
   typedef logic signed [SumW-1:0] sum_type;

   // shift controls passed down the cell row
   typedef struct packed {
      logic load;
      logic rotate;
      logic clear;
   } row_ctl_type;
endpackage
`default_nettype wire

// ===== design/otwm_cell.sv =====
`default_nettype none
module otwm_cell
   import otwm_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  row_ctl_type ctl,
   input  sample_type  load_data,
   input  sample_type  prev_data,
   output sample_type  data
);
   sample_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.clear) begin
         data_in = '0;
      end else if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.rotate) begin
         data_in = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;
endmodule
`default_nettype wire

// ===== design/otwm_div.sv =====
`default_nettype none
module otwm_div
   import otwm_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      start,
   input  sum_type  dividend,
   input  cnt_type  divisor,
   output logic     done,
   output sum_type  quotient
);
   localparam int unsigned StepW = $clog2(SumW + 1);

   logic [SumW-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [SumW-1:0] mag;
   logic [StepW-1:0] step_ff, step_in;
   logic busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   cnt_type den_ff, den_in;
   logic [SumW:0] trial;
   logic [SumW-1:0] shifted;

   always_comb begin
      mag = dividend[SumW-1] ? SumW'(-dividend) : SumW'(dividend);
      rem_in = rem_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      den_in = den_ff;
      done_in = 1'b0;
      shifted = {rem_ff[SumW-2:0], quo_ff[SumW-1]};
      trial = {1'b0, shifted} - (SumW+1)'(den_ff);
      if (start) begin
         rem_in = '0;
         quo_in = mag;
         step_in = '0;
         busy_in = 1'b1;
         neg_in = dividend[SumW-1];
         den_in = divisor;
      end else if (busy_ff) begin
         if (!trial[SumW]) begin
            rem_in = trial[SumW-1:0];
            quo_in = {quo_ff[SumW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[SumW-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == StepW'(SumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
      neg_ff <= neg_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? sum_type'(-quo_ff) : sum_type'(quo_ff);
endmodule
`default_nettype wire

// ===== design/otwm_axis.sv =====
`default_nettype none
module otwm_axis
   import otwm_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  row_ctl_type ctl,
   input  sample_type  sample,
   input  wire         acc_clear,
   input  wire         acc_sum,
   input  wire         acc_dist,
   input  wire         acc_trim,
   input  slot_type    pos,
   input  wire         div_start,
   input  wire         div_sel,
   input  cnt_type     count,
   output logic        div_done,
   output sample_type  result
);
   sample_type cells [Window];
   row_ctl_type cell_ctl [Window];
   sum_type sum_ff, sum_in, mean_ff, mean_in, worst_ff, worst_in, delta;
   slot_type drop_ff, drop_in;
   sum_type quotient, dividend;
   cnt_type divisor;
   sample_type head;

   genvar g;
   generate
      for (g = 0; g < Window; g++) begin : g_cell
         // only cell 0 takes the new sample
         assign cell_ctl[g] = {ctl.load && (g == 0), ctl.rotate, ctl.clear};
         otwm_cell u_cell (
            .clock(clock),
            .reset(reset),
            .ctl(cell_ctl[g]),
            .load_data(sample),
            .prev_data(cells[(g + 1) % Window]),
            .data(cells[g])
         );
      end
   endgenerate

   // cell 0 holds slot pos while the row rotates
   assign head = cells[0];

   always_comb begin
      sum_in = sum_ff;
      worst_in = worst_ff;
      drop_in = drop_ff;
      mean_in = mean_ff;
      delta = mean_ff - sum_type'(head);
      if (delta < 0) begin
         delta = -delta;
      end
      if (acc_clear) begin
         sum_in = '0;
         worst_in = '0;
         drop_in = '0;
      end else if (acc_sum) begin
         sum_in = sum_ff + sum_type'(head);
      end else if (acc_dist) begin
         if (delta >= worst_ff) begin
            worst_in = delta;
            drop_in = pos;
         end
      end else if (acc_trim) begin
         if (pos != drop_ff) begin
            sum_in = sum_ff + sum_type'(head);
         end
      end
      if (div_done && !div_sel) begin
         mean_in = quotient;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      worst_ff <= worst_in;
      drop_ff <= drop_in;
      mean_ff <= mean_in;
   end

   assign dividend = sum_ff;
   assign divisor = div_sel ? cnt_type'(count - 1'b1) : count;

   otwm_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(dividend),
      .divisor(divisor),
      .done(div_done),
      .quotient(quotient)
   );

   assign result = quotient[15:0];
endmodule
`default_nettype wire

// ===== design/outlier_trimmed_window_mean.sv =====
// flow: the first sample after reset or restart is passed straight to the output; any later
// sample goes through row alignment, load, a sum pass, a division, distance and trim passes
// and a second division; either result then waits while the previous one is still stalled
// requests: one sample at a time; req_stall stays high until that sample's result is registered
// reset: synchronous, active high; clears all cells, the slot and the fill count
`default_nettype none
module outlier_trimmed_window_mean
   import otwm_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [15:0] req_sample_x,
   input  wire [15:0] req_sample_y,
   input  wire [15:0] req_sample_z,
   input  wire        req_restart,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [15:0] rsp_filtered_x,
   output logic [15:0] rsp_filtered_y,
   output logic [15:0] rsp_filtered_z
);
   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StAlign = 4'd1;
   localparam logic [3:0] StLoad  = 4'd2;
   localparam logic [3:0] StSum   = 4'd3;
   localparam logic [3:0] StDiv1  = 4'd4;
   localparam logic [3:0] StWait1 = 4'd5;
   localparam logic [3:0] StDist  = 4'd6;
   localparam logic [3:0] StTrim  = 4'd7;
   localparam logic [3:0] StDiv2  = 4'd8;
   localparam logic [3:0] StWait2 = 4'd9;
   localparam logic [3:0] StOut   = 4'd10;

   logic [3:0] state_ff, state_in;
   slot_type slot_ff, slot_in, pos_ff, pos_in;
   slot_type rot_ff, rot_in;
   cnt_type seen_ff, seen_in;
   logic [CntW:0] k_ff, k_in;
   logic valid_ff, valid_in;
   sample_type ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   sample_type sx_ff, sy_ff, sz_ff;
   row_ctl_type ctl;
   logic acc_clear, acc_sum, acc_dist, acc_trim, div_start, div_sel;
   logic [NumAxes-1:0] dd;
   sample_type rx, ry, rz;
   logic accept;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != StIdle);

   // row rotation: cell 0 shows slot rot_ff; rotating advances by one
   always_comb begin
      state_in = state_ff;
      slot_in = slot_ff;
      pos_in = pos_ff;
      rot_in = rot_ff;
      seen_in = seen_ff;
      k_in = k_ff;
      valid_in = valid_ff && rsp_stall;
      ox_in = ox_ff;
      oy_in = oy_ff;
      oz_in = oz_ff;
      ctl = '0;
      acc_clear = 1'b0;
      acc_sum = 1'b0;
      acc_dist = 1'b0;
      acc_trim = 1'b0;
      div_start = 1'b0;
      div_sel = 1'b0;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               if (req_restart) begin
                  ctl.clear = 1'b1;
                  slot_in = '0;
                  seen_in = '0;
                  rot_in = '0;
               end
               state_in = StAlign;
            end
         end
         StAlign: begin
            // rotate until cell 0 holds the write slot
            if (rot_ff == slot_ff) begin
               state_in = StLoad;
            end else begin
               ctl.rotate = 1'b1;
               rot_in = rot_ff + 1'b1;
            end
         end
         StLoad: begin
            ctl.load = 1'b1;
            slot_in = (slot_ff == slot_type'(Window - 1)) ? '0 : slot_ff + 1'b1;
            if (seen_ff == '0) begin
               seen_in = cnt_type'(1);
               state_in = StOut;
            end else begin
               if (seen_ff < cnt_type'(Window)) begin
                  seen_in = seen_ff + 1'b1;
               end
               state_in = StSum;
               acc_clear = 1'b1;
               k_in = '0;
               pos_in = '0;
            end
         end
         StSum, StDist, StTrim: begin
            // visit every slot once starting from rot_ff alignment at slot 0
            if (rot_ff != '0 && k_ff == '0) begin
               ctl.rotate = 1'b1;
               rot_in = rot_ff + 1'b1;
            end else begin
               if (k_ff < (CntW+1)'(seen_ff)) begin
                  acc_sum = (state_ff == StSum);
                  acc_dist = (state_ff == StDist);
                  acc_trim = (state_ff == StTrim);
               end
               pos_in = pos_ff + 1'b1;
               ctl.rotate = 1'b1;
               rot_in = rot_ff + 1'b1;
               k_in = k_ff + 1'b1;
               if (k_ff == (CntW+1)'(Window - 1)) begin
                  k_in = '0;
                  case (state_ff)
                     StSum: state_in = StDiv1;
                     StDist: state_in = StTrim;
                     default: state_in = StDiv2;
                  endcase
               end
            end
         end
         StDiv1: begin
            div_start = 1'b1;
            state_in = StWait1;
         end
         StWait1: begin
            if (&dd) begin
               // fresh accumulators for the distance and trim passes
               acc_clear = 1'b1;
               state_in = StDist;
            end
         end
         StDiv2: begin
            div_start = 1'b1;
            div_sel = 1'b1;
            state_in = StWait2;
         end
         StWait2: begin
            div_sel = 1'b1;
            if (&dd) begin
               state_in = StOut;
            end
         end
         StOut: begin
            if (!(valid_ff && rsp_stall)) begin
               if (seen_ff == cnt_type'(1)) begin
                  ox_in = sx_ff;
                  oy_in = sy_ff;
                  oz_in = sz_ff;
               end else begin
                  ox_in = rx;
                  oy_in = ry;
                  oz_in = rz;
               end
               valid_in = 1'b1;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
      if (state_ff == StTrim && state_in == StDiv2) begin
         acc_clear = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         slot_ff <= '0;
         seen_ff <= '0;
         rot_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff <= slot_in;
         seen_ff <= seen_in;
         rot_ff <= rot_in;
         valid_ff <= valid_in;
      end
      pos_ff <= pos_in;
      k_ff <= k_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      oz_ff <= oz_in;
      if (accept) begin
         sx_ff <= req_sample_x;
         sy_ff <= req_sample_y;
         sz_ff <= req_sample_z;
      end
   end

   otwm_axis u_x (
      .clock(clock), .reset(reset), .ctl(ctl), .sample(sx_ff),
      .acc_clear(acc_clear), .acc_sum(acc_sum), .acc_dist(acc_dist),
      .acc_trim(acc_trim), .pos(pos_ff), .div_start(div_start), .div_sel(div_sel),
      .count(seen_ff), .div_done(dd[0]), .result(rx)
   );
   otwm_axis u_y (
      .clock(clock), .reset(reset), .ctl(ctl), .sample(sy_ff),
      .acc_clear(acc_clear), .acc_sum(acc_sum), .acc_dist(acc_dist),
      .acc_trim(acc_trim), .pos(pos_ff), .div_start(div_start), .div_sel(div_sel),
      .count(seen_ff), .div_done(dd[1]), .result(ry)
   );
   otwm_axis u_z (
      .clock(clock), .reset(reset), .ctl(ctl), .sample(sz_ff),
      .acc_clear(acc_clear), .acc_sum(acc_sum), .acc_dist(acc_dist),
      .acc_trim(acc_trim), .pos(pos_ff), .div_start(div_start), .div_sel(div_sel),
      .count(seen_ff), .div_done(dd[2]), .result(rz)
   );

   assign rsp_valid = valid_ff;
   assign rsp_filtered_x = ox_ff;
   assign rsp_filtered_y = oy_ff;
   assign rsp_filtered_z = oz_ff;
endmodule
`default_nettype wire

// ===== design/otwm_checker.sv =====
`default_nettype none
`include "outlier_trimmed_window_mean_macros.svh"
module otwm_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [15:0] rsp_filtered_x
);
   `OTWM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `OTWM_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
      $stable(rsp_filtered_x))
   `OTWM_ASSERT_NXT(a_one_busy, clock, reset, req_valid && !req_stall, req_stall)
   `OTWM_ASSERT_IMP(a_reset_idle, clock, 1'b0, $past(reset), !rsp_valid)
endmodule

bind outlier_trimmed_window_mean otwm_checker u_otwm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_filtered_x(rsp_filtered_x)
);
`default_nettype wire

// ===== tb/sv/otwm_checker.sv =====
module otwm_tb_checker
   import otwm_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        req_stall,
   input  wire [15:0] req_sample_x,
   input  wire [15:0] req_sample_y,
   input  wire [15:0] req_sample_z,
   input  wire        req_restart,
   input  wire        rsp_valid,
   input  wire        rsp_stall,
   input  wire [15:0] rsp_filtered_x,
   input  wire [15:0] rsp_filtered_y,
   input  wire [15:0] rsp_filtered_z,
   output int         fail_count,
   output int         pending_count,
   output int         results_seen
);
   typedef struct packed {
      sample_type fx;
      sample_type fy;
      sample_type fz;
   } mean_beat_type;

   sample_type xw[Window];
   sample_type yw[Window];
   sample_type zw[Window];
   int unsigned slot_now;
   int unsigned fill_now;
   mean_beat_type mean_queue[$];

   function automatic sample_type axis_trim(sample_type w[Window], int unsigned n);
      longint s;
      longint m;
      longint d;
      longint worst;
      int unsigned drop;
      s = 0;
      worst = 0;
      drop = 0;
      for (int i = 0; i < n; i++) s += w[i];
      m = s / longint'(n);
      for (int i = 0; i < n; i++) begin
         d = m - w[i];
         if (d < 0) d = -d;
         if (d >= worst) begin
            worst = d;
            drop = i;
         end
      end
      s = 0;
      for (int i = 0; i < n; i++) if (i != drop) s += w[i];
      return sample_type'(s / longint'(n - 1));
   endfunction

   function automatic mean_beat_type predict_mean(sample_type sx, sample_type sy,
                                                  sample_type sz, logic rs);
      mean_beat_type r;
      if (rs) begin
         for (int i = 0; i < Window; i++) begin
            xw[i] = '0;
            yw[i] = '0;
            zw[i] = '0;
         end
         slot_now = 0;
         fill_now = 0;
      end
      xw[slot_now] = sx;
      yw[slot_now] = sy;
      zw[slot_now] = sz;
      slot_now = (slot_now + 1) % Window;
      if (fill_now == 0) begin
         fill_now = 1;
         r.fx = sx;
         r.fy = sy;
         r.fz = sz;
      end else begin
         if (fill_now < Window) fill_now++;
         r.fx = axis_trim(xw, fill_now);
         r.fy = axis_trim(yw, fill_now);
         r.fz = axis_trim(zw, fill_now);
      end
      return r;
   endfunction

   assign pending_count = mean_queue.size();

   always @(posedge clock) begin
      mean_beat_type e;
      if (reset) begin
         for (int i = 0; i < Window; i++) begin
            xw[i] = '0;
            yw[i] = '0;
            zw[i] = '0;
         end
         slot_now = 0;
         fill_now = 0;
         mean_queue.delete();
         fail_count <= 0;
         results_seen <= 0;
      end else begin
         if (req_valid && !req_stall)
            mean_queue.push_back(predict_mean(req_sample_x, req_sample_y,
                                              req_sample_z, req_restart));
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (mean_queue.size() == 0) begin
               $display("%0t: unexpected beat x=%h y=%h z=%h", $time,
                        rsp_filtered_x, rsp_filtered_y, rsp_filtered_z);
               fail_count <= fail_count + 1;
            end else begin
               e = mean_queue.pop_front();
               if (e.fx !== rsp_filtered_x || e.fy !== rsp_filtered_y ||
                   e.fz !== rsp_filtered_z) begin
                  $display("%0t: mismatch expected x=%h y=%h z=%h actual x=%h y=%h z=%h",
                           $time, e.fx, e.fy, e.fz,
                           rsp_filtered_x, rsp_filtered_y, rsp_filtered_z);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/sv/outlier_trimmed_window_mean_tb.sv =====
module outlier_trimmed_window_mean_tb;
   import otwm_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [15:0] req_sample_x = 0;
   logic [15:0] req_sample_y = 0;
   logic [15:0] req_sample_z = 0;
   logic req_restart = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [15:0] rsp_filtered_x;
   logic [15:0] rsp_filtered_y;
   logic [15:0] rsp_filtered_z;
   int fail_count;
   int pending_count;
   int results_seen;
   int idle_cycles = 0;
   int sent_count = 0;
   int restarts_sent = 0;
   logic hold_off = 0;
   localparam int IdleLimit = 20000;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   outlier_trimmed_window_mean DUT (.*);

   otwm_tb_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("watchdog expired");
         $display("[outlier_trimmed_window_mean] ERROR");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      int mode;
      mode = $urandom_range(0, 99);
      if (hold_off) rsp_stall <= 1;
      else if ((sent_count / 200) % 2 == 0) rsp_stall <= 0;
      else rsp_stall <= (mode < 40);
   end

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         4: return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_beat(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic rs);
      req_valid <= 1;
      req_sample_x <= x;
      req_sample_y <= y;
      req_sample_z <= z;
      req_restart <= rs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      if (rs) restarts_sent++;
   endtask

   task automatic go_idle(int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int burst;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, ties, wrap
      send_beat(16'h7fff, 16'h8000, 16'h0000, 1);
      send_beat(16'h8000, 16'h7fff, 16'hffff, 0);
      send_beat(16'h7fff, 16'h8000, 16'h0001, 0);
      send_beat(16'h0005, 16'h0005, 16'h0005, 1);
      send_beat(16'h0005, 16'h0005, 16'h0005, 0);
      send_beat(16'h0007, 16'hfffd, 16'h0003, 0);
      for (int i = 0; i < 18; i++)
         send_beat(pick_value(), pick_value(), pick_value(), 0);
      send_beat(16'h1234, 16'h8001, 16'h7ffe, 1);
      go_idle(3);
      // long receiver hold-off while the sender keeps offering beats
      fork
         begin
            hold_off <= 1;
            repeat (600) @(posedge clock);
            hold_off <= 0;
         end
         for (int i = 0; i < 6; i++)
            send_beat(pick_value(), pick_value(), pick_value(), 0);
      join
      while (sent_count < 1525) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst; i++)
            send_beat(pick_value(), pick_value(), pick_value(),
                      $urandom_range(0, 49) == 0);
         if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 150));
      end
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d beats (%0d restarts), checked %0d results",
               sent_count, restarts_sent, results_seen);
      if (fail_count == 0 && pending_count == 0)
         $display("[outlier_trimmed_window_mean] OK");
      else
         $display("[outlier_trimmed_window_mean] ERROR");
      $finish;
   end
endmodule
